### rtl/agef_pkg.sv
// Package for the adaptive gain EMA filter: delta thresholds, gain codes,
// widths and the default channel count. No dependencies.
package agef_pkg;

   localparam int DEFAULT_CHANNELS = 2;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int DELTA_W  = 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [GAIN_W-1:0]   gain_type;
   typedef logic        [DELTA_W-1:0]  delta_type;

   // Whole-mA delta thresholds (strictly greater than)
   localparam delta_type DELTA_LIM_0 = 8'd250;
   localparam delta_type DELTA_LIM_1 = 8'd75;
   localparam delta_type DELTA_LIM_2 = 8'd25;
   localparam delta_type DELTA_LIM_3 = 8'd10;
   localparam delta_type DELTA_LIM_4 = 8'd5;
   localparam delta_type DELTA_LIM_5 = 8'd2;
   localparam delta_type DELTA_MAX   = 8'd255;

   // Gains in unsigned Q0.16, rounded to nearest
   localparam gain_type GAIN_0950 = 16'd62259;
   localparam gain_type GAIN_0800 = 16'd52429;
   localparam gain_type GAIN_0400 = 16'd26214;
   localparam gain_type GAIN_0200 = 16'd13107;
   localparam gain_type GAIN_0100 = 16'd6554;
   localparam gain_type GAIN_0050 = 16'd3277;
   localparam gain_type GAIN_0025 = 16'd1638;

endpackage

### rtl/adaptive_gain_ema_filter.sv
// Adaptive gain EMA filter, top level: input register, one-pass update,
// result register. Depends on agef_pkg.
//
//  Channel   Ports                              Transfer
//  -------   --------------------------------   ---------------------------
//  request   req_valid/ready, channel, sample   one sample per transaction
//  response  rsp_valid/ready, filtered          one result per request
//
// One item per cycle while results are taken; a request passes through the input register, then the result register.
// The gain compare, 17x16 magnitude multiply and rounding add sit between the
// input register and the result register, which also writes the channel state.
// A stalled result holds the input register; a new request still enters while
// the input register drains. Reset clears every channel's value and the gain.
module adaptive_gain_ema_filter #(
   parameter int CHANNELS = agef_pkg::DEFAULT_CHANNELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_channel,
   input  logic signed [15:0]    req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [15:0]    rsp_filtered
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DIFF_W = agef_pkg::DIFF_W;
   localparam int PROD_W = DIFF_W + agef_pkg::GAIN_W;

   // Input register
   logic                 in_valid_ff;
   logic [CH_W-1:0]      in_ch_ff;
   agef_pkg::sample_type in_sample_ff;

   // State
   agef_pkg::sample_type smoothed_ff [CHANNELS];
   agef_pkg::gain_type   gain_ff;
   agef_pkg::gain_type   gain_in;

   // Result register
   logic                 out_valid_ff;
   agef_pkg::sample_type filtered_ff;
   agef_pkg::sample_type filtered_in;

   logic                 advance;
   logic                 fire;
   logic [CH_W-1:0]      req_ch_idx;

   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        mag;
   agef_pkg::delta_type      delta;
   logic [PROD_W-1:0]        prod;
   logic [PROD_W-1:0]        prod_rnd;
   logic [DIFF_W-1:0]        step_mag;
   logic signed [DIFF_W:0]   step;
   logic signed [DIFF_W:0]   sum;
   agef_pkg::sample_type     cur;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid    = out_valid_ff;
   assign rsp_filtered = filtered_ff;

   // Channel index reduced modulo CHANNELS (one-bit input)
   assign req_ch_idx = (CHANNELS == 1) ? CH_W'(0) : CH_W'(req_channel);

   always_comb begin
      cur   = smoothed_ff[in_ch_ff];
      diff  = DIFF_W'(in_sample_ff) - DIFF_W'(cur);
      mag   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      // whole-mA distance, saturated
      delta = (mag[DIFF_W-1:4] > DIFF_W'(agef_pkg::DELTA_MAX)) ?
              agef_pkg::DELTA_MAX : mag[11:4];

      priority if (delta > agef_pkg::DELTA_LIM_0) gain_in = agef_pkg::GAIN_0950;
      else if (delta > agef_pkg::DELTA_LIM_1)     gain_in = agef_pkg::GAIN_0800;
      else if (delta > agef_pkg::DELTA_LIM_2)     gain_in = agef_pkg::GAIN_0400;
      else if (delta > agef_pkg::DELTA_LIM_3)     gain_in = agef_pkg::GAIN_0200;
      else if (delta > agef_pkg::DELTA_LIM_4)     gain_in = agef_pkg::GAIN_0100;
      else if (delta > agef_pkg::DELTA_LIM_5)     gain_in = agef_pkg::GAIN_0050;
      else if (delta != '0)                       gain_in = agef_pkg::GAIN_0025;
      else                                        gain_in = gain_ff;

      // round half away from zero on the magnitude, then restore the sign
      prod     = PROD_W'(mag) * PROD_W'(gain_in);
      prod_rnd = prod + PROD_W'(32768);
      step_mag = prod_rnd[PROD_W-1:16];
      step     = diff[DIFF_W-1] ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
      sum      = (DIFF_W+1)'(cur) + step;

      if (sum > (DIFF_W+1)'(32767))
         filtered_in = 16'sh7FFF;
      else if (sum < -(DIFF_W+1)'(32768))
         filtered_in = 16'sh8000;
      else
         filtered_in = sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         gain_ff      <= '0;
         for (int i = 0; i < CHANNELS; i++)
            smoothed_ff[i] <= '0;
      end else begin
         if (req_ready)
            in_valid_ff <= req_valid;
         if (advance)
            out_valid_ff <= in_valid_ff;
         if (fire) begin
            gain_ff               <= gain_in;
            smoothed_ff[in_ch_ff] <= filtered_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ch_ff     <= req_ch_idx;
         in_sample_ff <= req_sample;
      end
      if (fire)
         filtered_ff <= filtered_in;
   end

endmodule
